@@ rtl/core/sorted_priority_message_queue_unit_defines.svh @@
// ----------------------------------------------------------------------------
// sorted priority message queue - assertion macros
// shared property wrappers, clocked on clk and disabled during arst_n
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_MESSAGE_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_MESSAGE_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication
`define SPMQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spmq assertion failed");

// next-cycle implication
`define SPMQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spmq assertion failed");

`endif

@@ rtl/core/spmq_pkg.sv @@
// ----------------------------------------------------------------------------
// spmq_pkg
// shared types, sizes, codes and bit-vector helpers of the priority queue
// ----------------------------------------------------------------------------
package spmq_pkg;

	localparam int DEPTH      = 16;
	localparam int MSG_BITS   = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int PRIO_W     = 8;
	localparam int MSG_WORD_W = 32;
	localparam int LIVE_W     = 5;

	localparam logic [PRIO_W-1:0] PRIO_SPLIT = 8'd127;

	// request codes
	localparam logic [1:0] REQ_ENQ       = 2'd0;
	localparam logic [1:0] REQ_POP_TAIL  = 2'd1;
	localparam logic [1:0] REQ_POP_EXACT = 2'd2;
	localparam logic [1:0] REQ_POP_BOUND = 2'd3;

	// status codes
	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_EMPTY    = 2'd1;
	localparam logic [1:0] STS_NO_MATCH = 2'd2;
	localparam logic [1:0] STS_FULL     = 2'd3;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [PRIO_W-1:0]     prio;
		logic [MSG_WORD_W-1:0] msg_word;
	} req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic [PRIO_W-1:0]     removed_prio;
		logic [MSG_WORD_W-1:0] removed_msg;
		logic [LIVE_W-1:0]     live_count;
	} rsp_t;

	typedef struct packed {
		logic load;   // capture the incoming request
		logic exec;   // update slots and load the response register
	} dp_cmd_t;

	// keep only the lowest set bit
	function automatic logic [DEPTH-1:0] lowest_oh(input logic [DEPTH-1:0] v);
		return v & (~v + DEPTH'(1));
	endfunction

	function automatic logic [DEPTH-1:0] bit_rev(input logic [DEPTH-1:0] v);
		logic [DEPTH-1:0] r;
		for (int i = 0; i < DEPTH; i++) begin
			r[i] = v[DEPTH-1-i];
		end
		return r;
	endfunction

	// keep only the highest set bit
	function automatic logic [DEPTH-1:0] highest_oh(input logic [DEPTH-1:0] v);
		return bit_rev(lowest_oh(bit_rev(v)));
	endfunction

endpackage

@@ rtl/core/sorted_priority_message_queue_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_message_queue_unit
// bounded queue of (priority, message) entries kept sorted highest first
// ----------------------------------------------------------------------------
// usage:
//   request channel (req_valid / req_stall / req_data) carries one request:
//   enqueue, remove tail, remove exact priority, or remove tail if at or
//   below a bound. a request is taken when req_valid is high and req_stall
//   is low at a rising edge of clk.
//   response channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
//   response per request: status, removed entry (zero if none) and the
//   number of entries held afterwards.
//   the controller first captures the request, then performs the parallel
//   compare and slot shift across all DEPTH slots and loads the response
//   register; it takes no new request until both steps are done. the exec
//   step waits while an earlier response is still stalled.
//   a stalled response holds in its output register; the block still takes
//   the next request and finishes it once that register is drained.
//   reset: the queue is empty, no response is pending, req_stall is low.
//   a full queue reports status full and drops the new entry.
// ----------------------------------------------------------------------------
module sorted_priority_message_queue_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  spmq_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output spmq_pkg::rsp_t rsp_data
);

	// command bundle from sequencer to slot datapath
	spmq_pkg::dp_cmd_t cmd;

	// sequencer: idle -> exec, holds in exec while the response is stalled
	spmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	// slots, count, compare/shift logic and response register
	spmq_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req_in  (req_data),
		.rsp_out (rsp_data)
	);

endmodule

@@ rtl/core/spmq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spmq_ctrl
// two-state sequencer: capture a request, then execute it into the response
// ----------------------------------------------------------------------------
module spmq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spmq_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   req_stall_q;
	logic   rsp_valid_q;

	always_comb begin
		cmd.load = (state_q == S_IDLE) && req_valid;
		cmd.exec = (state_q == S_EXEC) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_stall_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q     <= S_EXEC;
						req_stall_q <= 1'b1;
					end
				end
				S_EXEC: begin
					// wait here while a finished response is still held
					if (cmd.exec) begin
						state_q     <= S_IDLE;
						req_stall_q <= 1'b0;
					end
				end
			endcase
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = req_stall_q;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ rtl/core/spmq_datapath.sv @@
// ----------------------------------------------------------------------------
// spmq_datapath
// sorted slot registers with parallel compare, shift insert and shift remove
// ----------------------------------------------------------------------------
module spmq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  spmq_pkg::dp_cmd_t cmd,
	input  spmq_pkg::req_t    req_in,
	output spmq_pkg::rsp_t    rsp_out
);

	logic [spmq_pkg::PRIO_W-1:0]   prio_q [spmq_pkg::DEPTH];
	logic [spmq_pkg::MSG_BITS-1:0] msg_q  [spmq_pkg::DEPTH];
	logic [spmq_pkg::CNT_W-1:0]    count_q;
	spmq_pkg::req_t                req_s1;
	spmq_pkg::rsp_t                rsp_q;

	// neighbor taps for shifting
	logic [spmq_pkg::PRIO_W-1:0]   prev_prio [spmq_pkg::DEPTH];
	logic [spmq_pkg::MSG_BITS-1:0] prev_msg  [spmq_pkg::DEPTH];
	logic [spmq_pkg::PRIO_W-1:0]   next_prio [spmq_pkg::DEPTH];
	logic [spmq_pkg::MSG_BITS-1:0] next_msg  [spmq_pkg::DEPTH];

	logic [spmq_pkg::DEPTH-1:0] live, ge, eq, le;
	logic [spmq_pkg::DEPTH-1:0] tail_oh, ins_oh, ins_after, rm_oh, rm_after, pick;
	logic                       full, empty, do_ins, do_rm;
	logic [1:0]                 status;
	logic [spmq_pkg::MSG_BITS-1:0]   new_msg;
	logic [spmq_pkg::MSG_BITS+spmq_pkg::MSG_WORD_W-1:0] msg_in_ext;
	logic [spmq_pkg::MSG_BITS+spmq_pkg::MSG_WORD_W-1:0] msg_out_ext;
	logic [spmq_pkg::PRIO_W-1:0]     rm_prio;
	logic [spmq_pkg::MSG_BITS-1:0]   rm_msg;
	logic [spmq_pkg::CNT_W-1:0]      count_nxt;
	logic [spmq_pkg::CNT_W+spmq_pkg::LIVE_W-1:0] live_ext;

	for (genvar g = 0; g < spmq_pkg::DEPTH; g++) begin : g_tap
		if (g == 0) begin : g_head
			assign prev_prio[g] = '0;
			assign prev_msg[g]  = '0;
		end else begin : g_body
			assign prev_prio[g] = prio_q[g-1];
			assign prev_msg[g]  = msg_q[g-1];
		end
		if (g == spmq_pkg::DEPTH - 1) begin : g_last
			assign next_prio[g] = prio_q[g];
			assign next_msg[g]  = msg_q[g];
		end else begin : g_inner
			assign next_prio[g] = prio_q[g+1];
			assign next_msg[g]  = msg_q[g+1];
		end
	end

	// per-slot compares
	always_comb begin
		for (int i = 0; i < spmq_pkg::DEPTH; i++) begin
			live[i] = spmq_pkg::CNT_W'(i) < count_q;
			ge[i]   = live[i] && (req_s1.prio >= prio_q[i]);
			eq[i]   = live[i] && (req_s1.prio == prio_q[i]);
			le[i]   = prio_q[i] <= req_s1.prio;
		end
	end

	always_comb begin
		full    = count_q == spmq_pkg::CNT_W'(spmq_pkg::DEPTH);
		empty   = count_q == '0;
		tail_oh = live & ~(live >> 1);
		// insert ahead of the first slot at or below the new priority, else after tail
		if (|ge) begin
			ins_oh = spmq_pkg::lowest_oh(ge);
		end else begin
			ins_oh = ~live & {live[spmq_pkg::DEPTH-2:0], 1'b1};
		end
		ins_after = ~(ins_oh - spmq_pkg::DEPTH'(1));
		// high priorities match newest first, low ones oldest first
		if (req_s1.prio > spmq_pkg::PRIO_SPLIT) begin
			pick = spmq_pkg::lowest_oh(eq);
		end else begin
			pick = spmq_pkg::highest_oh(eq);
		end

		status = spmq_pkg::STS_OK;
		rm_oh  = '0;
		do_ins = 1'b0;
		unique case (req_s1.req_type)
			spmq_pkg::REQ_ENQ: begin
				if (full) begin
					status = spmq_pkg::STS_FULL;
				end else begin
					do_ins = 1'b1;
				end
			end
			spmq_pkg::REQ_POP_TAIL: begin
				if (empty) begin
					status = spmq_pkg::STS_EMPTY;
				end else begin
					rm_oh = tail_oh;
				end
			end
			spmq_pkg::REQ_POP_EXACT: begin
				if (empty) begin
					status = spmq_pkg::STS_EMPTY;
				end else if (pick == '0) begin
					status = spmq_pkg::STS_NO_MATCH;
				end else begin
					rm_oh = pick;
				end
			end
			spmq_pkg::REQ_POP_BOUND: begin
				if (empty) begin
					status = spmq_pkg::STS_EMPTY;
				end else if ((tail_oh & le) == '0) begin
					status = spmq_pkg::STS_NO_MATCH;
				end else begin
					rm_oh = tail_oh;
				end
			end
		endcase
		do_rm    = |rm_oh;
		rm_after = ~(rm_oh - spmq_pkg::DEPTH'(1));

		rm_prio = '0;
		rm_msg  = '0;
		for (int i = 0; i < spmq_pkg::DEPTH; i++) begin
			if (rm_oh[i]) begin
				rm_prio = rm_prio | prio_q[i];
				rm_msg  = rm_msg | msg_q[i];
			end
		end

		if (do_ins) begin
			count_nxt = count_q + spmq_pkg::CNT_W'(1);
		end else if (do_rm) begin
			count_nxt = count_q - spmq_pkg::CNT_W'(1);
		end else begin
			count_nxt = count_q;
		end

		msg_in_ext  = {{spmq_pkg::MSG_BITS{1'b0}}, req_s1.msg_word};
		new_msg     = msg_in_ext[spmq_pkg::MSG_BITS-1:0];
		msg_out_ext = {{spmq_pkg::MSG_WORD_W{1'b0}}, rm_msg};
		live_ext    = {{spmq_pkg::LIVE_W{1'b0}}, count_nxt};
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < spmq_pkg::DEPTH; i++) begin
				if (do_ins && ins_after[i]) begin
					if (ins_oh[i]) begin
						prio_q[i] <= req_s1.prio;
						msg_q[i]  <= new_msg;
					end else begin
						prio_q[i] <= prev_prio[i];
						msg_q[i]  <= prev_msg[i];
					end
				end else if (do_rm && rm_after[i]) begin
					prio_q[i] <= next_prio[i];
					msg_q[i]  <= next_msg[i];
				end
			end
			rsp_q.status       <= status;
			rsp_q.removed_prio <= rm_prio;
			rsp_q.removed_msg  <= msg_out_ext[spmq_pkg::MSG_WORD_W-1:0];
			rsp_q.live_count   <= live_ext[spmq_pkg::LIVE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			req_s1  <= '0;
		end else begin
			if (cmd.load) begin
				req_s1 <= req_in;
			end
			if (cmd.exec) begin
				count_q <= count_nxt;
			end
		end
	end

	assign rsp_out = rsp_q;

endmodule

@@ rtl/core/spmq_checker.sv @@
// ----------------------------------------------------------------------------
// spmq_checker
// port-level checks on the priority queue, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_priority_message_queue_unit_defines.svh"

module spmq_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input spmq_pkg::rsp_t rsp_data
);

	logic rsp_fail;
	logic rsp_empty;
	logic rsp_full;
	logic rm_zero;
	logic at_capacity;

	assign rsp_fail    = rsp_valid && (rsp_data.status != spmq_pkg::STS_OK);
	assign rsp_empty   = rsp_valid && (rsp_data.status == spmq_pkg::STS_EMPTY);
	assign rsp_full    = rsp_valid && (rsp_data.status == spmq_pkg::STS_FULL);
	assign rm_zero     = (rsp_data.removed_prio == '0) && (rsp_data.removed_msg == '0);
	assign at_capacity = rsp_data.live_count == spmq_pkg::LIVE_W'(spmq_pkg::DEPTH);

	// stalled response holds
	`SPMQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

	// one request in flight: a taken request closes the input
	`SPMQ_ASSERT_NEXT(a_one_inflight, req_valid && !req_stall, req_stall)

	// no removed entry reported unless the request succeeded
	`SPMQ_ASSERT_IMP(a_zero_on_fail, rsp_fail, rm_zero)

	// empty status only with nothing held
	`SPMQ_ASSERT_IMP(a_empty_count, rsp_empty, rsp_data.live_count == '0)

	// full status only at capacity
	`SPMQ_ASSERT_IMP(a_full_count, rsp_full, at_capacity)

endmodule

bind sorted_priority_message_queue_unit spmq_checker u_spmq_checker (.*);

@@ tb/spmq_shadow_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spmq_shadow_pkg
// shadow copy of the sorted priority queue that predicts every response and
// checks the responses of the block against them in order
// ----------------------------------------------------------------------------
package spmq_shadow_pkg;

	import spmq_pkg::*;

	class spmq_shadow_queue;

		logic [PRIO_W-1:0]     slot_prio [DEPTH];
		logic [MSG_WORD_W-1:0] slot_msg  [DEPTH];
		int                    held;
		rsp_t                  pending_rsp [$];
		int unsigned           mismatch_cnt;
		int unsigned           rsp_checked;
		int unsigned           status_hits [4];

		function new();
			held = 0;
			mismatch_cnt = 0;
			rsp_checked = 0;
			foreach (status_hits[i]) status_hits[i] = 0;
		endfunction

		// take slot pos out and close the gap behind it
		function void take_slot(input int pos, inout rsp_t o);
			o.removed_prio = slot_prio[pos];
			o.removed_msg = slot_msg[pos];
			for (int i = pos; i + 1 < held; i++) begin
				slot_prio[i] = slot_prio[i + 1];
				slot_msg[i] = slot_msg[i + 1];
			end
			held--;
		endfunction

		// update the shadow slots for one request, return its response
		function rsp_t apply_request(input req_t r);
			rsp_t o;
			int   pos;
			bit   hit;
			o = '0;
			pos = 0;
			hit = 1'b0;
			if (r.req_type == REQ_ENQ) begin
				if (held >= DEPTH) begin
					o.status = STS_FULL;
				end else begin
					// ahead of the first entry from the head with equal or lower priority
					pos = held;
					for (int i = held - 1; i >= 0; i--) begin
						if (r.prio >= slot_prio[i]) pos = i;
					end
					for (int i = held; i > pos; i--) begin
						slot_prio[i] = slot_prio[i - 1];
						slot_msg[i] = slot_msg[i - 1];
					end
					slot_prio[pos] = r.prio;
					slot_msg[pos] = r.msg_word & MSG_WORD_W'((64'd1 << MSG_BITS) - 64'd1);
					held++;
				end
			end else if (held == 0) begin
				o.status = STS_EMPTY;
			end else begin
				case (r.req_type)
					REQ_POP_TAIL: begin
						pos = held - 1;
						hit = 1'b1;
					end
					REQ_POP_EXACT: begin
						if (r.prio > PRIO_SPLIT) begin
							// newest among equals, nearest the head
							for (int i = held - 1; i >= 0; i--) begin
								if (slot_prio[i] == r.prio) begin
									pos = i;
									hit = 1'b1;
								end
							end
						end else begin
							// oldest among equals, nearest the tail
							for (int i = 0; i < held; i++) begin
								if (slot_prio[i] == r.prio) begin
									pos = i;
									hit = 1'b1;
								end
							end
						end
					end
					default: begin
						pos = held - 1;
						hit = (slot_prio[held - 1] <= r.prio);
					end
				endcase
				if (hit) take_slot(pos, o);
				else o.status = STS_NO_MATCH;
			end
			o.live_count = LIVE_W'(held);
			return o;
		endfunction

		function void note_request(input req_t r);
			rsp_t o;
			o = apply_request(r);
			status_hits[o.status]++;
			pending_rsp.push_back(o);
		endfunction

		function void check_response(input rsp_t got);
			rsp_t want;
			rsp_checked++;
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with no request waiting: st=%0d prio=%0d msg=%h cnt=%0d",
					$time, got.status, got.removed_prio, got.removed_msg, got.live_count);
				mismatch_cnt++;
				return;
			end
			want = pending_rsp.pop_front();
			if (got.status !== want.status || got.removed_prio !== want.removed_prio ||
				got.removed_msg !== want.removed_msg || got.live_count !== want.live_count) begin
				$display("%0t: mismatch, expected st=%0d prio=%0d msg=%h cnt=%0d",
					$time, want.status, want.removed_prio, want.removed_msg, want.live_count);
				$display("%0t:           actual   st=%0d prio=%0d msg=%h cnt=%0d",
					$time, got.status, got.removed_prio, got.removed_msg, got.live_count);
				mismatch_cnt++;
			end
		endfunction

	endclass

endpackage

@@ tb/sorted_priority_message_queue_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_message_queue_unit_tb
// drives directed and random requests into the sorted priority queue under
// several idling patterns and checks each response against a shadow queue
// ----------------------------------------------------------------------------
module sorted_priority_message_queue_unit_tb;

	import spmq_pkg::*;
	import spmq_shadow_pkg::*;

	localparam int RANDOM_PER_PHASE = 150;
	localparam int PHASE_CNT        = 4;
	localparam int GOAL_SPAN        = 25;
	localparam int STALL_LIMIT      = 1000;
	localparam int DRAIN_CYCLES     = 8;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data  = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp_data;

	// idling knobs in percent per cycle, then watchdog and request counters
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned sent_cnt       = 0;

	spmq_shadow_queue shadow;

	sorted_priority_message_queue_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// response monitor: every taken response goes to the shadow queue
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) shadow.check_response(rsp_data);
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic req_t make_request(input logic [1:0] kind, input logic [PRIO_W-1:0] p,
		input logic [MSG_WORD_W-1:0] m);
		req_t r;
		r.req_type = kind;
		r.prio = p;
		r.msg_word = m;
		return r;
	endfunction

	// present one request, hold it until taken, then log it with the shadow
	task automatic send_request(input req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		shadow.note_request(r);
		sent_cnt++;
	endtask

	// random request steered toward a fill level so the queue fills, drains
	// and overflows; removals mostly aim at live priorities or the tail
	function automatic req_t pick_request(input int fill_goal);
		req_t r;
		int   roll;
		int   tail_p;
		r.msg_word = $urandom;
		r.prio = PRIO_W'($urandom_range(255));
		roll = $urandom_range(99);
		if (roll < 5) begin
			// noise: any request type with any fields
			r.req_type = 2'($urandom_range(3));
		end else if ((shadow.held < fill_goal) ? (roll < 75) : (roll < 30)) begin
			r.req_type = REQ_ENQ;
			// clustered priorities so equal entries pile up
			if ($urandom_range(1)) begin
				case ($urandom_range(5))
					0: r.prio = 8'd0;
					1: r.prio = 8'd64;
					2: r.prio = PRIO_SPLIT;
					3: r.prio = PRIO_SPLIT + 8'd1;
					4: r.prio = 8'd192;
					default: r.prio = 8'd255;
				endcase
			end
		end else begin
			case ($urandom_range(2))
				0: r.req_type = REQ_POP_TAIL;
				1: r.req_type = REQ_POP_EXACT;
				default: r.req_type = REQ_POP_BOUND;
			endcase
			if (shadow.held > 0) begin
				if (r.req_type == REQ_POP_EXACT && $urandom_range(9) < 7) begin
					r.prio = shadow.slot_prio[$urandom_range(shadow.held - 1)];
				end else if (r.req_type == REQ_POP_BOUND && $urandom_range(9) < 6) begin
					// bound just around the tail priority
					tail_p = int'(shadow.slot_prio[shadow.held - 1]) + int'($urandom_range(4)) - 2;
					if (tail_p < 0) tail_p = 0;
					if (tail_p > 255) tail_p = 255;
					r.prio = PRIO_W'(tail_p);
				end
			end
		end
		return r;
	endfunction

	initial begin
		int fill_goal;
		shadow = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: removals on an empty queue
		send_request(make_request(REQ_POP_TAIL, 8'd0, 32'h0));
		send_request(make_request(REQ_POP_EXACT, 8'd200, 32'h0));
		send_request(make_request(REQ_POP_BOUND, 8'd255, 32'h0));
		// field extremes and equal priorities on both sides of the split
		send_request(make_request(REQ_ENQ, 8'd0, 32'h0000_0000));
		send_request(make_request(REQ_ENQ, 8'd255, 32'hffff_ffff));
		send_request(make_request(REQ_ENQ, PRIO_SPLIT, 32'h1111_0001));
		send_request(make_request(REQ_ENQ, PRIO_SPLIT + 8'd1, 32'h2222_0001));
		send_request(make_request(REQ_ENQ, PRIO_SPLIT, 32'h1111_0002));
		send_request(make_request(REQ_ENQ, PRIO_SPLIT + 8'd1, 32'h2222_0002));
		// fill up, then one request into a full queue
		for (int i = 0; i < DEPTH - 6; i++) begin
			send_request(make_request(REQ_ENQ, PRIO_W'($urandom_range(254, 1)), $urandom));
		end
		send_request(make_request(REQ_ENQ, 8'd77, 32'hdead_beef));
		// exact removal from the tail side and from the head side
		send_request(make_request(REQ_POP_EXACT, PRIO_SPLIT, 32'h0));
		send_request(make_request(REQ_POP_EXACT, PRIO_SPLIT + 8'd1, 32'h0));
		send_request(make_request(REQ_POP_TAIL, 8'd0, 32'h0));
		// no match: bound below the tail, exact priority not held; then a bound that matches
		send_request(make_request(REQ_POP_BOUND, 8'd0, 32'h0));
		send_request(make_request(REQ_POP_EXACT, 8'd0, 32'h0));
		send_request(make_request(REQ_POP_BOUND, 8'd255, 32'h0));

		// random phases: no idling, sender idle, receiver stalling, both
		fill_goal = 0;
		for (int ph = 0; ph < PHASE_CNT; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 53;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 53;
				end
				default: begin
					send_idle_pct = 17;
					recv_stall_pct = 17;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				// new fill level now and then; above DEPTH pushes into overflow
				if (n % GOAL_SPAN == 0) fill_goal = $urandom_range(DEPTH + 1);
				send_request(pick_request(fill_goal));
			end
		end
		req_valid <= 1'b0;

		// wait for every response, then a quiet drain period before the report
		while (shadow.pending_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d requests over %0d idling phases, %0d responses checked",
			sent_cnt, PHASE_CNT, shadow.rsp_checked);
		$display("run: status ok %0d, empty %0d, no match %0d, full %0d",
			shadow.status_hits[STS_OK], shadow.status_hits[STS_EMPTY],
			shadow.status_hits[STS_NO_MATCH], shadow.status_hits[STS_FULL]);
		if (shadow.mismatch_cnt == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/spmq_pkg.sv
rtl/core/spmq_ctrl.sv
rtl/core/spmq_datapath.sv
rtl/core/sorted_priority_message_queue_unit.sv
rtl/core/spmq_checker.sv
tb/spmq_shadow_pkg.sv
tb/sorted_priority_message_queue_unit_tb.sv
